// ===== rtl/m3p_pkg.sv =====
// Shared constants and control types for the 3x3 matrix power unit.
package m3p_pkg;

  // Default parameter values.
  localparam int EXP_BITS_DEF   = 31;
  localparam int ELEM_WIDTH_DEF = 32;

  // Matrix geometry.
  localparam int MAT_DIM  = 3;
  localparam int MAT_SIZE = MAT_DIM * MAT_DIM;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BIT  = 5'b00010,
    S_SQR  = 5'b00100,
    S_WAIT = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // Write-back control that travels with a product issued to the lanes.
  typedef struct packed {
    logic valid;
    logic to_acc;
  } wb_ctrl_t;

endpackage

// ===== rtl/m3p_lane.sv =====
// One product lane: a registered 3-term dot product for one matrix element.
module m3p_lane #(
  parameter int ELEM_WIDTH = m3p_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         issue,
  input  logic [m3p_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0]  row_a,
  input  logic [m3p_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0]  col_b,
  output logic [ELEM_WIDTH-1:0]                        sum
);

  logic [ELEM_WIDTH-1:0] prod [m3p_pkg::MAT_DIM];

  // Capture the wrapped partial products of one row by one column.
  always_ff @(posedge clk) begin
    if (issue) begin
      for (int k = 0; k < m3p_pkg::MAT_DIM; k++) begin
        prod[k] <= ELEM_WIDTH'(row_a[k] * col_b[k]);
      end
    end
  end

  // Reduce the partial products, wrapping to the element width.
  always_comb begin
    sum = '0;
    for (int k = 0; k < m3p_pkg::MAT_DIM; k++) begin
      sum = sum + prod[k];
    end
  end

endmodule

// ===== rtl/matrix3_power_by_squaring_unit.sv =====
// Top level of the 3x3 matrix power unit: sequencer, lane array and merge.
//
// Usage:
//   The input channel (in_valid / in_ready) carries a base matrix b00..b22
//   and an exponent. The output channel (out_valid / out_ready) carries the
//   power matrix p00..p22, every element wrapped to ELEM_WIDTH bits.
//   The time from the accepting edge to out_valid grows with the position
//   of the highest set exponent bit and with the number of set bits.
//   Each exponent bit costs one squaring and, when set, one extra multiply
//   on the nine shared lanes; each product is registered in the lanes and
//   then written back, and the next bit waits for the squared power.
//   One transaction is in work at a time; in_ready rises again in the cycle
//   after the result moves into the output register, so a new transaction
//   can start while the previous result still waits for out_ready.
//   If the receiver stalls and a second result is done, the unit holds it
//   with in_ready low until the output register frees.
//   Reset (rst, synchronous) drops out_valid and returns the unit to idle.
module matrix3_power_by_squaring_unit #(
  parameter int EXP_BITS   = m3p_pkg::EXP_BITS_DEF,
  parameter int ELEM_WIDTH = m3p_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEM_WIDTH-1:0] b00,
  input  logic signed [ELEM_WIDTH-1:0] b01,
  input  logic signed [ELEM_WIDTH-1:0] b02,
  input  logic signed [ELEM_WIDTH-1:0] b10,
  input  logic signed [ELEM_WIDTH-1:0] b11,
  input  logic signed [ELEM_WIDTH-1:0] b12,
  input  logic signed [ELEM_WIDTH-1:0] b20,
  input  logic signed [ELEM_WIDTH-1:0] b21,
  input  logic signed [ELEM_WIDTH-1:0] b22,
  input  logic        [EXP_BITS-1:0]   exponent,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ELEM_WIDTH-1:0] p00,
  output logic signed [ELEM_WIDTH-1:0] p01,
  output logic signed [ELEM_WIDTH-1:0] p02,
  output logic signed [ELEM_WIDTH-1:0] p10,
  output logic signed [ELEM_WIDTH-1:0] p11,
  output logic signed [ELEM_WIDTH-1:0] p12,
  output logic signed [ELEM_WIDTH-1:0] p20,
  output logic signed [ELEM_WIDTH-1:0] p21,
  output logic signed [ELEM_WIDTH-1:0] p22
);

  localparam int DIM  = m3p_pkg::MAT_DIM;
  localparam int SIZE = m3p_pkg::MAT_SIZE;

  m3p_pkg::state_t   state, state_next;
  m3p_pkg::wb_ctrl_t wb, wb_next;

  logic [ELEM_WIDTH-1:0] acc     [SIZE];
  logic [ELEM_WIDTH-1:0] pwr     [SIZE];
  logic [ELEM_WIDTH-1:0] in_mat  [SIZE];
  logic [ELEM_WIDTH-1:0] lane_sum[SIZE];
  logic [EXP_BITS-1:0]   exp_rem;

  logic in_fire;
  logic issue;
  logic sel_acc;
  logic fin_load;

  assign in_mat[0] = b00;
  assign in_mat[1] = b01;
  assign in_mat[2] = b02;
  assign in_mat[3] = b10;
  assign in_mat[4] = b11;
  assign in_mat[5] = b12;
  assign in_mat[6] = b20;
  assign in_mat[7] = b21;
  assign in_mat[8] = b22;

  assign in_ready = (state == m3p_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_load = (state == m3p_pkg::S_FIN) && (!out_valid || out_ready);

  // Sequence the multiply and square steps of each exponent bit.
  always_comb begin
    state_next = state;
    wb_next    = '0;
    issue      = 1'b0;
    sel_acc    = 1'b0;
    unique case (state)
      m3p_pkg::S_IDLE: begin
        if (in_fire) state_next = m3p_pkg::S_BIT;
      end
      m3p_pkg::S_BIT: begin
        if (exp_rem == '0) begin
          state_next = m3p_pkg::S_FIN;
        end else if (exp_rem[0]) begin
          issue          = 1'b1;
          sel_acc        = 1'b1;
          wb_next.valid  = 1'b1;
          wb_next.to_acc = 1'b1;
          state_next     = m3p_pkg::S_SQR;
        end else begin
          issue         = 1'b1;
          wb_next.valid = 1'b1;
          state_next    = m3p_pkg::S_WAIT;
        end
      end
      m3p_pkg::S_SQR: begin
        issue         = 1'b1;
        wb_next.valid = 1'b1;
        state_next    = m3p_pkg::S_WAIT;
      end
      m3p_pkg::S_WAIT: begin
        state_next = m3p_pkg::S_BIT;
      end
      m3p_pkg::S_FIN: begin
        if (fin_load) state_next = m3p_pkg::S_IDLE;
      end
      default: state_next = m3p_pkg::S_IDLE;
    endcase
  end

  // Lane array: lane (r, c) forms row r of the left operand by column c of
  // the running power.
  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      logic [DIM-1:0][ELEM_WIDTH-1:0] row_a;
      logic [DIM-1:0][ELEM_WIDTH-1:0] col_b;
      always_comb begin
        for (int k = 0; k < DIM; k++) begin
          row_a[k] = sel_acc ? acc[r*DIM+k] : pwr[r*DIM+k];
          col_b[k] = pwr[k*DIM+c];
        end
      end
      m3p_lane #(
        .ELEM_WIDTH(ELEM_WIDTH)
      ) u_lane (
        .clk  (clk),
        .issue(issue),
        .row_a(row_a),
        .col_b(col_b),
        .sum  (lane_sum[r*DIM+c])
      );
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= m3p_pkg::S_IDLE;
      wb        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wb        <= wb_next;
      out_valid <= fin_load || (out_valid && !out_ready);
    end
  end

  // Merge lane results into the accumulator or the running power; load a
  // new transaction; advance the exponent.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      exp_rem <= exponent;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          acc[r*DIM+c] <= (r == c) ? ELEM_WIDTH'(1) : '0;
          pwr[r*DIM+c] <= in_mat[r*DIM+c];
        end
      end
    end else begin
      if (wb.valid) begin
        for (int i = 0; i < SIZE; i++) begin
          if (wb.to_acc) acc[i] <= lane_sum[i];
          else           pwr[i] <= lane_sum[i];
        end
      end
      if (state == m3p_pkg::S_WAIT) exp_rem <= exp_rem >> 1;
    end
  end

  // Hold the finished result in the output register.
  always_ff @(posedge clk) begin
    if (fin_load) begin
      p00 <= acc[0];
      p01 <= acc[1];
      p02 <= acc[2];
      p10 <= acc[3];
      p11 <= acc[4];
      p12 <= acc[5];
      p20 <= acc[6];
      p21 <= acc[7];
      p22 <= acc[8];
    end
  end

endmodule

// ===== rtl/m3p_checker.sv =====
// Port-level checks for the 3x3 matrix power unit, bound to the top level.
module m3p_checker #(
  parameter int ELEM_WIDTH = m3p_pkg::ELEM_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ELEM_WIDTH-1:0] p00,
  input logic [ELEM_WIDTH-1:0] p01,
  input logic [ELEM_WIDTH-1:0] p02,
  input logic [ELEM_WIDTH-1:0] p10,
  input logic [ELEM_WIDTH-1:0] p11,
  input logic [ELEM_WIDTH-1:0] p12,
  input logic [ELEM_WIDTH-1:0] p20,
  input logic [ELEM_WIDTH-1:0] p21,
  input logic [ELEM_WIDTH-1:0] p22
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(p00) && $stable(p01) &&
      $stable(p02) && $stable(p10) && $stable(p11) && $stable(p12) &&
      $stable(p20) && $stable(p21) && $stable(p22))
    else $error("stalled result changed or dropped");

  // Go busy after every accepted transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in work");

  // Raise a result only out of a busy cycle.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in work");

  // Come out of reset idle and empty.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("unit not idle after reset");

endmodule

bind matrix3_power_by_squaring_unit m3p_checker #(
  .ELEM_WIDTH(ELEM_WIDTH)
) u_m3p_checker (.*);
